### design/tss_pkg.sv
package tss_pkg;

  // Port field widths
  localparam int AngleW = 32;
  localparam int SineW  = 30;
  localparam int TermsW = 5;
  localparam int EpsW   = 29;

  // Series length limit
  localparam int MaxTerms = 16;
  localparam int CountW   = 6;

  // Internal fixed-point widths (magnitudes in Q.40 unless noted)
  localparam int AxW        = 31;  // |angle| in Q.28, at most 4.0
  localparam int X2W        = 45;  // x*x in Q.40
  localparam int TermW      = 48;  // term magnitude in Q.40
  localparam int ChunkW     = TermW / 2;
  localparam int ProdW      = 2 * ChunkW;
  localparam int MaccW      = 4 * ChunkW;
  localparam int SumW       = 50;  // signed Q.40 accumulator
  localparam int FracShift  = 12;  // Q.40 to Q.28
  localparam int ProdShift  = 40;  // drop of the term product

  // Iterative divider by (2n)(2n+1)
  localparam int DivW        = 13;
  localparam int DivStepBits = 8;
  localparam int DivSteps    = TermW / DivStepBits;

  // Sequencer step counter
  localparam int StepW    = 3;
  localparam int MulSteps = 4;

  // Q4.28 constants
  localparam int LimQ28 = 1 << 30;
  localparam int OneQ28 = 1 << 28;

  // Configuration map
  localparam int PaddrW     = 3;
  localparam int RegEpsilon = 0;
  localparam int EpsReset   = 268;

  typedef struct packed {
    logic       load;
    logic       square;
    logic       add_term;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       macc_en;
    logic       div_load;
    logic       div_step;
    logic       next_term;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic below_thr;
    logic at_cap;
  } status_t;

endpackage

### design/tss_ctrl.sv
module tss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  tss_pkg::status_t status_i,
  output tss_pkg::cmd_t    cmd_o
);

  localparam int StepW = tss_pkg::StepW;

  typedef enum logic [2:0] {
    StIdle,
    StSquare,
    StAdd,
    StMul,
    StDivLoad,
    StDiv,
    StCheck,
    StFinish
  } state_e;

  state_e                    state_q, state_d;
  logic [tss_pkg::StepW-1:0] step_q, step_d;
  logic                      out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StSquare;
        end
      end
      StSquare: begin
        cmd_o.square = 1'b1;
        state_d      = StAdd;
      end
      StAdd: begin
        cmd_o.add_term = 1'b1;
        step_d         = '0;
        state_d        = StMul;
      end
      StMul: begin
        // issue partial products, accumulate each in the cycle after it is issued
        cmd_o.mul_en  = (step_q < StepW'(tss_pkg::MulSteps));
        cmd_o.mul_sel = step_q[1:0];
        cmd_o.macc_en = (step_q != '0);
        step_d        = step_q + StepW'(1);
        if (step_q == StepW'(tss_pkg::MulSteps)) begin
          state_d = StDivLoad;
        end
      end
      StDivLoad: begin
        cmd_o.div_load = 1'b1;
        step_d         = '0;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + StepW'(1);
        if (step_q == StepW'(tss_pkg::DivSteps - 1)) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        cmd_o.next_term = 1'b1;
        if (status_i.below_thr || status_i.at_cap) begin
          state_d = StFinish;
        end else begin
          state_d = StAdd;
        end
      end
      StFinish: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### design/tss_datapath.sv
module tss_datapath (
  input  logic                               clk_i,
  input  tss_pkg::cmd_t                      cmd_i,
  output tss_pkg::status_t                   status_o,
  input  logic signed [tss_pkg::AngleW-1:0]  angle_i,
  input  logic        [tss_pkg::EpsW-1:0]    eps_i,
  output logic signed [tss_pkg::SineW-1:0]   sine_value_o,
  output logic        [tss_pkg::TermsW-1:0]  terms_used_o,
  output logic                               hit_cap_o
);

  localparam int AngleW = tss_pkg::AngleW;
  localparam int AxW    = tss_pkg::AxW;
  localparam int X2W    = tss_pkg::X2W;
  localparam int TermW  = tss_pkg::TermW;
  localparam int ChunkW = tss_pkg::ChunkW;
  localparam int ProdW  = tss_pkg::ProdW;
  localparam int MaccW  = tss_pkg::MaccW;
  localparam int SumW   = tss_pkg::SumW;
  localparam int DivW   = tss_pkg::DivW;
  localparam int CountW = tss_pkg::CountW;
  localparam int SineW  = tss_pkg::SineW;
  localparam int EpsW   = tss_pkg::EpsW;
  localparam int FracSh = tss_pkg::FracShift;
  localparam int MagW   = SumW - FracSh;

  logic [AxW-1:0]    ax_q;
  logic              neg_q;
  logic [X2W-1:0]    x2_q;
  logic [TermW-1:0]  term_q;
  logic              tneg_q;
  logic [SumW-1:0]   sum_q;
  logic [CountW-1:0] count_q;
  logic [ProdW-1:0]  prod_q;
  logic [1:0]        prod_sh_q;
  logic [MaccW-1:0]  macc_q;
  logic [TermW-1:0]  dvd_q;
  logic [DivW-1:0]   rem_q;
  logic [DivW-1:0]   div_q;
  logic              cap_q;
  logic [SineW-1:0]  sine_q;
  logic [tss_pkg::TermsW-1:0] terms_q;
  logic              hit_cap_q;

  // Angle magnitude, saturated to 4.0
  logic [AngleW-1:0] mag_raw;
  logic [AxW-1:0]    ax_d;
  always_comb begin
    mag_raw = angle_i[AngleW-1] ? (~angle_i + AngleW'(1)) : angle_i;
    if (mag_raw > AngleW'(tss_pkg::LimQ28)) begin
      ax_d = AxW'(tss_pkg::LimQ28);
    end else begin
      ax_d = mag_raw[AxW-1:0];
    end
  end

  logic [2*AxW-1:0] sq;
  assign sq = {{AxW{1'b0}}, ax_q} * {{AxW{1'b0}}, ax_q};

  logic [SumW-1:0] term_ext;
  logic [SumW-1:0] sum_d;
  assign term_ext = {{(SumW - TermW){1'b0}}, term_q};
  assign sum_d    = tneg_q ? (sum_q - term_ext) : (sum_q + term_ext);

  // One 24x24 partial product per cycle
  logic [ChunkW-1:0] a_chunk, b_chunk;
  assign a_chunk = cmd_i.mul_sel[1] ? term_q[TermW-1:ChunkW] : term_q[ChunkW-1:0];
  assign b_chunk = cmd_i.mul_sel[0] ? {{(2*ChunkW - X2W){1'b0}}, x2_q[X2W-1:ChunkW]}
                                    : x2_q[ChunkW-1:0];

  logic [MaccW-1:0] prod_aligned;
  always_comb begin
    case (prod_sh_q)
      2'd0:    prod_aligned = {{(MaccW - ProdW){1'b0}}, prod_q};
      2'd1:    prod_aligned = {{ChunkW{1'b0}}, prod_q, {ChunkW{1'b0}}};
      2'd2:    prod_aligned = {prod_q, {(MaccW - ProdW){1'b0}}};
      default: prod_aligned = '0;
    endcase
  end

  // Divisor (2n)(2n+1) with n equal to the terms added so far
  logic [CountW:0]     c2;
  logic [2*CountW+1:0] d_full;
  assign c2     = {count_q, 1'b0};
  assign d_full = {{(CountW + 1){1'b0}}, c2} * {{(CountW + 1){1'b0}}, count_q, 1'b1};

  // Restoring division, several quotient bits a cycle
  logic [TermW-1:0] dvd_d;
  logic [DivW-1:0]  rem_d;
  logic [DivW:0]    trial;
  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    trial = '0;
    for (int i = 0; i < tss_pkg::DivStepBits; i++) begin
      trial = {rem_d, dvd_d[TermW-1]};
      dvd_d = {dvd_d[TermW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial    = trial - {1'b0, div_q};
        dvd_d[0] = 1'b1;
      end
      rem_d = trial[DivW-1:0];
    end
  end

  logic [TermW-1:0] thr;
  assign thr = {{(TermW - EpsW - FracSh){1'b0}}, eps_i, {FracSh{1'b0}}};

  assign status_o.below_thr = (dvd_q < thr);
  assign status_o.at_cap    = (count_q >= CountW'(tss_pkg::MaxTerms));

  // Round half away from zero to Q.28, saturate to 1.0
  logic            sneg;
  logic [SumW-1:0] rsum;
  logic [MagW-1:0] mag;
  logic [SineW-1:0] mag_sat;
  logic [SineW-1:0] sine_d;
  always_comb begin
    sneg = sum_q[SumW-1];
    rsum = sneg ? (~sum_q + SumW'(2049)) : (sum_q + SumW'(2048));
    mag  = rsum[SumW-1:FracSh];
    if (mag > MagW'(tss_pkg::OneQ28)) begin
      mag_sat = SineW'(tss_pkg::OneQ28);
    end else begin
      mag_sat = mag[SineW-1:0];
    end
    sine_d = sneg ? (SineW'(0) - mag_sat) : mag_sat;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q  <= ax_d;
      neg_q <= angle_i[AngleW-1];
    end
    if (cmd_i.square) begin
      x2_q    <= sq[X2W+15:16];
      term_q  <= {{(TermW - AxW - FracSh){1'b0}}, ax_q, {FracSh{1'b0}}};
      tneg_q  <= neg_q;
      sum_q   <= '0;
      count_q <= '0;
    end
    if (cmd_i.add_term) begin
      sum_q   <= sum_d;
      count_q <= count_q + CountW'(1);
      macc_q  <= '0;
    end
    if (cmd_i.mul_en) begin
      prod_q    <= ProdW'(a_chunk) * ProdW'(b_chunk);
      prod_sh_q <= 2'(cmd_i.mul_sel[0]) + 2'(cmd_i.mul_sel[1]);
    end
    if (cmd_i.macc_en) begin
      macc_q <= macc_q + prod_aligned;
    end
    if (cmd_i.div_load) begin
      dvd_q <= macc_q[tss_pkg::ProdShift+TermW-1:tss_pkg::ProdShift];
      rem_q <= '0;
      div_q <= d_full[DivW-1:0];
    end
    if (cmd_i.div_step) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
    if (cmd_i.next_term) begin
      term_q <= dvd_q;
      tneg_q <= ~tneg_q;
      cap_q  <= ~status_o.below_thr;
    end
    if (cmd_i.out_load) begin
      sine_q    <= sine_d;
      terms_q   <= count_q[tss_pkg::TermsW-1:0];
      hit_cap_q <= cap_q;
    end
  end

  assign sine_value_o = sine_q;
  assign terms_used_o = terms_q;
  assign hit_cap_o    = hit_cap_q;

endmodule

### design/taylor_sine_series_top.sv
// Channel   Dir  Payload (tdata, low bit first)                      Transfer when
// s_axis    in   angle[31:0] signed Q4.28                            tvalid & tready
// m_axis    out  sine_value[29:0], terms_used[34:30], hit_cap[35]    tvalid & tready
// apb       in   epsilon at byte 0 (29 bits, unsigned Q.28)          psel & penable & pwrite
//
// Terms added per angle: 1 to 16.
//   Each term runs these steps: add, four 24x24 partial products on the one
//   multiplier plus a closing accumulate, divider load, six radix-256 divider
//   steps, stop check.
// One angle is worked at a time; s_axis_tready is high only in the idle state.
// A finished result waits in the output register, so the next angle is taken
// while it is still held; the sequencer stalls at the end only if it is not yet taken.
// Reset (rst_ni low, asynchronous) empties the output and sets epsilon to 268.
module taylor_sine_series_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,  // angle[31:0]
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [39:0]                  m_axis_tdata,  // sine_value[29:0], terms_used[34:30],
                                                      // hit_cap[35], zero[39:36]
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tss_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int EpsW   = tss_pkg::EpsW;
  localparam int PaddrW = tss_pkg::PaddrW;

  tss_pkg::cmd_t    cmd;
  tss_pkg::status_t status;

  logic [EpsW-1:0]                  eps_q;
  logic signed [tss_pkg::SineW-1:0] sine_value;
  logic [tss_pkg::TermsW-1:0]       terms_used;
  logic                             hit_cap;
  logic                             reg_hit;

  // Register file: epsilon only; word index taken from paddr above the byte bits
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PaddrW-1:2] == (PaddrW - 2)'(tss_pkg::RegEpsilon));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsW'(tss_pkg::EpsReset);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      eps_q <= pwdata[EpsW-1:0];
    end
  end

  assign prdata = reg_hit ? {{(32 - EpsW){1'b0}}, eps_q} : 32'd0;

  tss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tss_datapath u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .angle_i      (s_axis_tdata),
    .eps_i        (eps_q),
    .sine_value_o (sine_value),
    .terms_used_o (terms_used),
    .hit_cap_o    (hit_cap)
  );

  // Pack result fields from the low bit up, pad to whole bytes
  assign m_axis_tdata = {4'd0, hit_cap, terms_used, sine_value};

endmodule

### design/tss_checker.sv
module tss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // A held result must not change while the sink stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One angle at a time: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // Saturated result stays within plus or minus 1.0
  a_sine_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[29:0]) <= tss_pkg::OneQ28)
                   && ($signed(m_axis_tdata[29:0]) >= -tss_pkg::OneQ28))
    else $error("sine out of range");

  // Stopping at the term limit means the full count was used
  a_cap_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[35] |-> m_axis_tdata[34:30] == 5'(tss_pkg::MaxTerms))
    else $error("term limit flag without full count");

endmodule

bind taylor_sine_series_top tss_checker u_tss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### test/taylor_sine_series_top_test.sv
module taylor_sine_series_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Byte address of the epsilon register on the config port.
  localparam logic [tss_pkg::PaddrW-1:0] EpsAddr =
    tss_pkg::PaddrW'(tss_pkg::RegEpsilon * 4);
  // Cycles to linger after the last result: longest series plus margin.
  localparam int TailCycles = 3 + 14 * tss_pkg::MaxTerms + 20;

  // One result transfer, split into its fields.
  typedef struct packed {
    logic [3:0]                 pad;
    logic                       hit_cap;
    logic [tss_pkg::TermsW-1:0] terms_used;
    logic [tss_pkg::SineW-1:0]  sine_value;
  } sine_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;   // angle[31:0]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [39:0]       m_axis_tdata;        // sine_value[29:0], terms_used[34:30], hit_cap[35]
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [tss_pkg::PaddrW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Shadow of the epsilon register, the expected sines in order, and bookkeeping.
  logic [tss_pkg::EpsW-1:0] eps_shadow = tss_pkg::EpsW'(tss_pkg::EpsReset);
  sine_result_t    expected_sines[$];
  int unsigned     mismatches = 0;
  bit              gaps_on = 1'b1;
  int unsigned     rx_hold = 0;

  taylor_sine_series_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Sum the sine series the way the block does: magnitudes in Q.40, a signed
  // Q.40 accumulator, stop on epsilon first, then on the term cap.
  function automatic sine_result_t predict_sine(logic [31:0] angle);
    sine_result_t      res;
    logic              neg;
    logic              term_neg;
    logic [31:0]       ax;
    logic [63:0]       x_sq;
    logic [63:0]       thr;
    logic [63:0]       term;
    logic [95:0]       prod;
    logic signed [63:0] acc;
    logic [63:0]       mag;
    logic [63:0]       rounded;
    int unsigned       count;
    int unsigned       n;
    bit                stop;
    neg  = angle[31];
    ax   = neg ? (~angle + 32'd1) : angle;
    // Clamp to +/-4.0; the most negative code lands here as well.
    if (ax > 32'(tss_pkg::LimQ28)) ax = 32'(tss_pkg::LimQ28);
    x_sq = (64'(ax) * 64'(ax)) >> 16;
    thr  = 64'(eps_shadow) << tss_pkg::FracShift;
    term = 64'(ax) << tss_pkg::FracShift;
    term_neg = neg;
    acc   = '0;
    count = 0;
    n     = 1;
    stop  = 1'b0;
    res.hit_cap = 1'b0;
    while (!stop) begin
      if (term_neg) acc = acc - $signed(term);
      else          acc = acc + $signed(term);
      count++;
      prod = 96'(term) * 96'(x_sq);
      term = 64'(prod >> tss_pkg::ProdShift) / 64'((2 * n) * (2 * n + 1));
      term_neg = !term_neg;
      n++;
      if (term < thr) begin
        stop = 1'b1;
      end else if (count >= tss_pkg::MaxTerms) begin
        res.hit_cap = 1'b1;
        stop = 1'b1;
      end
    end
    // Round half away from zero into Q.28, then clamp to +/-1.0.
    mag     = acc[63] ? -acc : acc;
    rounded = (mag + 64'd2048) >> tss_pkg::FracShift;
    if (rounded > 64'(tss_pkg::OneQ28)) rounded = 64'(tss_pkg::OneQ28);
    if (acc[63]) rounded = -rounded;
    res.sine_value = rounded[tss_pkg::SineW-1:0];
    res.terms_used = count[tss_pkg::TermsW-1:0];
    res.pad        = '0;
    return res;
  endfunction

  // Idle length: mostly short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  // Mostly in-range angles, some near zero, some raw 32-bit noise beyond +/-4.0.
  function automatic logic [31:0] random_angle();
    logic [31:0] a;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      a = $urandom;
    end else if (r < 25) begin
      a = $urandom_range(0, 1 << 20);
      if ($urandom_range(0, 1)) a = -a;
    end else begin
      a = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    end
    return a;
  endfunction

  // Offer one angle; hold tvalid until the transfer and log its expected result.
  // Called at a falling edge, returns at a falling edge with tvalid still high.
  task automatic send_angle(logic [31:0] angle);
    int unsigned gap;
    gap = (gaps_on && $urandom_range(0, 1)) ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = angle;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_sines.insert(expected_sines.size(), predict_sine(angle));
    @(negedge clk_i);
  endtask

  // Drop the input and hold off until every expected sine has been taken.
  task automatic wait_sines_drained();
    s_axis_tvalid = 1'b0;
    while (expected_sines.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write epsilon over setup and access cycles, then read it back.
  task automatic write_epsilon(logic [31:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = EpsAddr;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    eps_shadow = value[tss_pkg::EpsW-1:0];
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(eps_shadow)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("epsilon readback: expected %h, got %h", 32'(eps_shadow), prdata);
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Output side: random stalls on tready, driven at the falling edge.
  always @(negedge clk_i) begin
    if (rx_hold == 0 && gaps_on && $urandom_range(0, 5) == 0) rx_hold = gap_len();
    if (rx_hold > 0) begin
      m_axis_tready = 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Compare each result transfer with the oldest expected sine.
  always @(posedge clk_i) begin : check_sines
    sine_result_t got;
    sine_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_sines.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = expected_sines.pop_front();
        if (got.sine_value !== want.sine_value || got.terms_used !== want.terms_used ||
            got.hit_cap !== want.hit_cap || got.pad !== want.pad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sine %h terms %0d cap %0d pad %h, expected %h terms %0d cap %0d",
                     got.sine_value, got.terms_used, got.hit_cap, got.pad,
                     want.sine_value, want.terms_used, want.hit_cap);
        end
      end
    end
  end

  // Reset value of epsilon, then the edges of the angle range and the classic points.
  task automatic test_reset_epsilon();
    logic [31:0] angles[14];
    angles = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h4000_0000, 32'hC000_0000, 32'h4000_0001,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h1000_0000, 32'hF000_0000,
               32'd421657428, -32'd421657428, 32'h2000_0000, 32'h3000_0000};
    write_epsilon(32'(tss_pkg::EpsReset));
    foreach (angles[i]) send_angle(angles[i]);
    wait_sines_drained();
  endtask

  // Epsilon of zero runs to the cap; each setting is tried with the angle 4.0 and a tiny angle.
  task automatic test_epsilon_extremes();
    logic [31:0] eps_vals[5];
    eps_vals = '{32'd0, 32'd1, 32'h1000_0000, 32'h1FFF_FFFF, 32'hFFFF_FFFF};
    foreach (eps_vals[i]) begin
      write_epsilon(eps_vals[i]);
      send_angle(32'h4000_0000);
      send_angle(32'd3);
      wait_sines_drained();
    end
  endtask

  // Random angles over several epsilon settings; one phase runs without idling.
  task automatic test_random_angles();
    logic [31:0] eps_vals[8];
    eps_vals = '{32'd1, 32'(tss_pkg::EpsReset), $urandom_range(1, 4096),
                 $urandom_range(1, 1 << 28), 32'd0, 32'h1000_0000,
                 $urandom_range(1 << 28, 32'h1FFF_FFFF), $urandom_range(4096, 1 << 20)};
    foreach (eps_vals[p]) begin
      write_epsilon(eps_vals[p]);
      gaps_on = (p != 2);
      for (int i = 0; i < 200; i++) begin
        // Hold off mid-phase until the output has caught up.
        if (i == 100) wait_sines_drained();
        send_angle(random_angle());
      end
      wait_sines_drained();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_epsilon();
    test_epsilon_extremes();
    test_random_angles();
    wait_sines_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_sines.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
